[rtl/core/archive_entry_decompressor_core_assert.svh]
// ---------------------------------------------------------------------------
// Archive entry decompressor assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ARCHIVE_ENTRY_DECOMPRESSOR_CORE_ASSERT_SVH
`define ARCHIVE_ENTRY_DECOMPRESSOR_CORE_ASSERT_SVH

// same-cycle implication
`define AED_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/aed_pkg.sv]
// ---------------------------------------------------------------------------
// Archive entry decompressor package
// Shared types, codes and widths.
// ---------------------------------------------------------------------------
package aed_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int POS_W      = 12;
  localparam int LEN_W      = 9;
  localparam int RS_W       = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_LEVEL      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_REF = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;

  localparam logic [2:0] LVL_STORED = 3'd0;
  localparam logic [2:0] LVL_RLE    = 3'd1;
  localparam logic [2:0] LVL_NONE   = 3'd7;

  typedef enum logic [2:0] {
    PH_FLAG    = 3'd0,
    PH_RLE_LIT = 3'd1,
    PH_RLE_REP = 3'd2,
    PH_LZ_ITEM = 3'd3,
    PH_LZ_REF2 = 3'd4
  } phase_t;

  typedef struct packed {
    logic load;
    logic put_in;
    logic put_ram;
    logic ring_in;
    logic ring_ram;
    logic rle_flag;
    logic rle_lit;
    logic rep_step;
    logic rep_done;
    logic lz_flags;
    logic lz_ref1;
    logic lz_ref2;
    logic next_tok;
    logic set_err;
    logic rd;
    logic cpy_step;
    logic flush;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] lvl;
    phase_t     phase;
    logic       tok;
    logic       halted;
    logic       left_zero;
    logic       len_zero;
    logic       pos_bad;
    logic       ref_zero;
    logic       pack_full;
    logic       out_free;
  } sts_t;

  function automatic logic [RS_W-1:0] ring_size(input logic [2:0] lvl);
    logic [RS_W-1:0] rs;
    case (lvl)
      3'd3:    rs = 13'd2048;
      3'd4:    rs = 13'd1024;
      3'd5:    rs = 13'd512;
      3'd6:    rs = 13'd256;
      default: rs = 13'd4096;
    endcase
    return rs;
  endfunction

endpackage

[rtl/core/aed_if.sv]
// ---------------------------------------------------------------------------
// Archive entry decompressor channels
// Input byte channel and packed result channel, valid/ready.
// ---------------------------------------------------------------------------
interface aed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, in_byte, stream_end, input ready);
  modport sink (input valid, in_byte, stream_end, output ready);
endinterface

interface aed_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic [1:0]  status;
  logic        run_last;
  modport source (output valid, out_bytes, byte_count, status, run_last, input ready);
  modport sink (input valid, out_bytes, byte_count, status, run_last, output ready);
endinterface

[rtl/core/aed_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module aed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/aed_datapath.sv]
// ---------------------------------------------------------------------------
// Archive entry decompressor datapath
// Parse state, window ring, byte packer and result register.
// ---------------------------------------------------------------------------
module aed_datapath import aed_pkg::*; #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            in_byte,
  input  logic                  in_stream_end,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_bytes,
  output logic [3:0]            out_byte_count,
  output logic [1:0]            out_status,
  output logic                  out_run_last
);
  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [2:0]   mode_r;
  logic [31:0]  exp_len_r;
  logic [7:0]   byte_r, byte_nxt;
  logic         end_r, end_nxt;
  logic [AW-1:0] wi_r, wi_nxt;
  logic [31:0]  prod_r, prod_nxt;
  phase_t       phase_r, phase_nxt;
  logic [7:0]   flags_r, flags_nxt;
  logic [2:0]   tbit_r, tbit_nxt;
  logic [7:0]   reflow_r, reflow_nxt;
  logic [7:0]   left_r, left_nxt;
  logic         halted_r, halted_nxt;
  logic         err_r, err_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [63:0]  pack_r, pack_nxt;
  logic [3:0]   pcnt_r, pcnt_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [63:0]  obytes_r, obytes_nxt;
  logic [3:0]   ocnt_r, ocnt_nxt;
  logic [1:0]   ost_r, ost_nxt;
  logic         olast_r, olast_nxt;

  logic [RS_W-1:0]  rs;
  logic [RS_W-1:0]  ring;
  logic [2:0]       ob;
  logic [POS_W-1:0] mask;
  logic [POS_W-1:0] pos_raw;
  logic [LEN_W-1:0] len_dec;
  logic [AW-1:0]    wi_eff;
  logic [RS_W-1:0]  wi_inc;
  logic [RS_W-1:0]  pos_inc;
  logic [7:0]       put_data;
  logic [7:0]       ram_rdata;
  logic             ring_en;
  logic [1:0]       st;
  logic             rle_left_done;

  assign ring   = ring_size(mode_r);
  assign rs     = (ring > RS_W'(WINDOW_DEPTH)) ? RS_W'(WINDOW_DEPTH) : ring;
  assign ob     = 3'd6 - mode_r;
  assign mask   = (POS_W'(1) << ob) - POS_W'(1);
  assign pos_raw = {4'b0, reflow_r} | (({4'b0, byte_r} & mask) << 8);
  assign len_dec = LEN_W'(2) + LEN_W'({1'b0, byte_r} >> ob);
  assign wi_eff = (RS_W'(wi_r) >= rs) ? '0 : wi_r;
  assign wi_inc = RS_W'(wi_eff) + RS_W'(1);
  assign pos_inc = RS_W'(pos_r) + RS_W'(1);
  assign put_data = cmd.put_ram ? ram_rdata : byte_r;
  assign ring_en = cmd.ring_in | cmd.ring_ram;
  assign rle_left_done = (left_r <= 8'd1);

  aed_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (ring_en),
    .waddr (wi_eff),
    .wdata (put_data),
    .raddr (pos_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (err_r) begin
      st = ST_BAD_REF;
    end else if (end_r && prod_r != exp_len_r) begin
      st = ST_LENGTH;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    sts.lvl       = mode_r;
    sts.phase     = phase_r;
    sts.tok       = flags_r[tbit_r];
    sts.halted    = halted_r;
    sts.left_zero = (left_r == 8'd0);
    sts.len_zero  = (len_r == '0);
    sts.pos_bad   = (RS_W'(pos_r) >= rs) || (32'(pos_r) >= prod_r);
    sts.ref_zero  = (pos_raw == '0);
    sts.pack_full = pcnt_r[3];
    sts.out_free  = !ovalid_r || out_ready;
  end

  always_comb begin
    byte_nxt = byte_r;
    end_nxt = end_r;
    wi_nxt = wi_r;
    prod_nxt = prod_r;
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    tbit_nxt = tbit_r;
    reflow_nxt = reflow_r;
    left_nxt = left_r;
    halted_nxt = halted_r;
    err_nxt = err_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    pack_nxt = pack_r;
    pcnt_nxt = pcnt_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obytes_nxt = obytes_r;
    ocnt_nxt = ocnt_r;
    ost_nxt = ost_r;
    olast_nxt = olast_r;

    if (cmd.load) begin
      byte_nxt = in_byte;
      end_nxt = in_stream_end;
      err_nxt = 1'b0;
    end
    if (cmd.put_in || cmd.put_ram) begin
      pack_nxt[{pcnt_r[2:0], 3'b000} +: 8] = put_data;
      pcnt_nxt = pcnt_r + 4'd1;
      prod_nxt = prod_r + 32'd1;
    end
    if (ring_en) begin
      wi_nxt = (wi_inc >= rs) ? '0 : AW'(wi_inc);
    end
    if (cmd.rle_flag) begin
      if (byte_r > 8'd127) begin
        left_nxt = byte_r - 8'd125;
        phase_nxt = PH_RLE_REP;
      end else begin
        left_nxt = byte_r + 8'd1;
        phase_nxt = PH_RLE_LIT;
      end
    end
    if (cmd.rle_lit) begin
      left_nxt = (left_r == 8'd0) ? 8'd0 : left_r - 8'd1;
      if (rle_left_done) begin
        phase_nxt = PH_FLAG;
      end
    end
    if (cmd.rep_step) begin
      left_nxt = left_r - 8'd1;
    end
    if (cmd.rep_done) begin
      left_nxt = 8'd0;
      phase_nxt = PH_FLAG;
    end
    if (cmd.lz_flags) begin
      flags_nxt = byte_r;
      tbit_nxt = 3'd0;
      phase_nxt = PH_LZ_ITEM;
    end
    if (cmd.lz_ref1) begin
      reflow_nxt = byte_r;
      phase_nxt = PH_LZ_REF2;
    end
    if (cmd.lz_ref2) begin
      pos_nxt = pos_raw - POS_W'(1);
      len_nxt = len_dec;
    end
    if (cmd.cpy_step) begin
      pos_nxt = (pos_inc >= rs) ? '0 : POS_W'(pos_inc);
      len_nxt = len_r - LEN_W'(1);
    end
    if (cmd.next_tok) begin
      if (tbit_r == 3'd7) begin
        tbit_nxt = 3'd0;
        phase_nxt = PH_FLAG;
      end else begin
        tbit_nxt = tbit_r + 3'd1;
        phase_nxt = PH_LZ_ITEM;
      end
    end
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end
    if (cmd.flush) begin
      ovalid_nxt = 1'b1;
      obytes_nxt = pack_r;
      ocnt_nxt = pcnt_r;
      ost_nxt = ST_OK;
      olast_nxt = 1'b0;
      pack_nxt = '0;
      pcnt_nxt = 4'd0;
    end
    if (cmd.finish) begin
      if (pcnt_r != 4'd0 || st != ST_OK || end_r) begin
        ovalid_nxt = 1'b1;
        obytes_nxt = pack_r;
        ocnt_nxt = pcnt_r;
        ost_nxt = st;
        olast_nxt = 1'b1;
      end
      pack_nxt = '0;
      pcnt_nxt = 4'd0;
      if (err_r) begin
        halted_nxt = 1'b1;
      end
      if (end_r) begin
        wi_nxt = '0;
        prod_nxt = 32'd0;
        phase_nxt = PH_FLAG;
        flags_nxt = 8'd0;
        tbit_nxt = 3'd0;
        reflow_nxt = 8'd0;
        left_nxt = 8'd0;
        halted_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LVL_STORED;
      exp_len_r <= 32'd0;
      wi_r <= '0;
      prod_r <= 32'd0;
      phase_r <= PH_FLAG;
      flags_r <= 8'd0;
      tbit_r <= 3'd0;
      reflow_r <= 8'd0;
      left_r <= 8'd0;
      halted_r <= 1'b0;
      err_r <= 1'b0;
      pack_r <= '0;
      pcnt_r <= 4'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE_LEVEL:      mode_r <= cfg_data[2:0];
          CFG_EXPECTED_LENGTH: exp_len_r <= cfg_data;
          default: ;
        endcase
      end
      wi_r <= wi_nxt;
      prod_r <= prod_nxt;
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      tbit_r <= tbit_nxt;
      reflow_r <= reflow_nxt;
      left_r <= left_nxt;
      halted_r <= halted_nxt;
      err_r <= err_nxt;
      pack_r <= pack_nxt;
      pcnt_r <= pcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r <= end_nxt;
    pos_r <= pos_nxt;
    len_r <= len_nxt;
    obytes_r <= obytes_nxt;
    ocnt_r <= ocnt_nxt;
    ost_r <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_bytes = obytes_r;
  assign out_byte_count = ocnt_r;
  assign out_status = ost_r;
  assign out_run_last = olast_r;
endmodule

[rtl/core/aed_ctrl.sv]
// ---------------------------------------------------------------------------
// Archive entry decompressor controller
// Sequences decode, run repeat, window copy and result completion.
// ---------------------------------------------------------------------------
module aed_ctrl import aed_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REP,
    S_CHECK,
    S_COPY,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   is_lz;

  assign is_lz = (sts.lvl != LVL_STORED) && (sts.lvl != LVL_RLE) && (sts.lvl != LVL_NONE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        if (sts.halted || sts.lvl == LVL_NONE) begin
          state_nxt = S_FINISH;
        end else if (sts.lvl == LVL_STORED) begin
          cmd.put_in = 1'b1;
        end else if (sts.lvl == LVL_RLE) begin
          case (sts.phase)
            PH_RLE_LIT: begin
              cmd.put_in = 1'b1;
              cmd.rle_lit = 1'b1;
            end
            PH_RLE_REP: state_nxt = S_REP;
            default: cmd.rle_flag = 1'b1;
          endcase
        end else if (is_lz) begin
          case (sts.phase)
            PH_LZ_ITEM: begin
              if (sts.tok) begin
                cmd.put_in = 1'b1;
                cmd.ring_in = 1'b1;
                cmd.next_tok = 1'b1;
              end else begin
                cmd.lz_ref1 = 1'b1;
              end
            end
            PH_LZ_REF2: begin
              if (sts.ref_zero) begin
                cmd.set_err = 1'b1;
                cmd.next_tok = 1'b1;
              end else begin
                cmd.lz_ref2 = 1'b1;
                state_nxt = S_CHECK;
              end
            end
            default: cmd.lz_flags = 1'b1;
          endcase
        end
      end
      S_REP: begin
        if (sts.left_zero) begin
          cmd.rep_done = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.pack_full) begin
          cmd.flush = sts.out_free;
        end else begin
          cmd.put_in = 1'b1;
          cmd.rep_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.len_zero) begin
          cmd.next_tok = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.pos_bad) begin
          cmd.set_err = 1'b1;
          cmd.next_tok = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.pack_full) begin
          cmd.flush = sts.out_free;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.put_ram = 1'b1;
        cmd.ring_ram = 1'b1;
        cmd.cpy_step = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
endmodule

[rtl/core/archive_entry_decompressor_core.sv]
// ---------------------------------------------------------------------------
// Archive entry decompressor core
// Stored, run-length and LZSS decoding of one compressed byte per
// transaction into packed results of up to eight bytes.
//
//   channel  direction  contents
//   in_ch    sink       in_byte, stream_end
//   out_ch   source     out_bytes, byte_count, status, run_last
//   cfg_*    write      mode_level (index 0), expected_length (index 1)
//
// A byte with no copy passes the accept, decode and finish states. A run
// repeat adds the repeat state; a window copy alternates the check and copy
// states per byte as the window RAM read is registered. Each full eight-byte
// result is flushed in the repeat or check state; a stalled out_ch holds the
// sequencer. Reset is synchronous; the window RAM needs no clearing pass.
// ---------------------------------------------------------------------------
module archive_entry_decompressor_core import aed_pkg::*; #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  aed_in_if.sink                in_ch,
  aed_out_if.source             out_ch
);
  cmd_t cmd;
  sts_t sts;

  aed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aed_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_byte        (in_ch.in_byte),
    .in_stream_end  (in_ch.stream_end),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_bytes      (out_ch.out_bytes),
    .out_byte_count (out_ch.byte_count),
    .out_status     (out_ch.status),
    .out_run_last   (out_ch.run_last)
  );
endmodule

[rtl/core/aed_checker.sv]
// ---------------------------------------------------------------------------
// Archive entry decompressor checker
// Port-level checks on result transactions, bound to the core.
// ---------------------------------------------------------------------------
`include "archive_entry_decompressor_core_assert.svh"

module aed_checker import aed_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bytes,
  input logic [3:0]  byte_count,
  input logic [1:0]  status,
  input logic        run_last
);
  `AED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bytes))
  `AED_ASSERT_IMPLY(a_count_range, out_valid, byte_count <= 4'd8)
  `AED_ASSERT_IMPLY(a_status_last, out_valid && status != ST_OK, run_last)
  `AED_ASSERT_IMPLY(a_mid_full, out_valid && !run_last, byte_count == 4'd8)
endmodule

bind archive_entry_decompressor_core aed_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_bytes  (out_ch.out_bytes),
  .byte_count (out_ch.byte_count),
  .status     (out_ch.status),
  .run_last   (out_ch.run_last)
);

[tb/sv/archive_entry_decompressor_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Archive entry decompressor core testbench
// Drives stored, run-length and LZSS streams through the byte channel, predicts
// every packed result from a local decoder, and checks each result transaction
// in order. A directed table comes first, then random streams under several
// idle and stall patterns.
// ---------------------------------------------------------------------------
module archive_entry_decompressor_core_test;
  import aed_pkg::*;

  localparam int RAM_DEPTH = 4096;
  localparam int BUF_MAX   = 272;
  localparam int SETTLE    = 40;
  localparam int LIMIT     = 1000000;
  localparam int RAND_ITEMS = 226;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic [1:0]  st;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        load_cfg;
    logic [2:0]  lvl;
    logic [31:0] elen;
    logic [7:0]  b;
    logic        fin;
    logic        typed;
    logic [63:0] data;
    logic [3:0]  cnt;
    logic [1:0]  st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  aed_in_if in_ch ();
  aed_out_if out_ch ();

  archive_entry_decompressor_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // decoder state: copy 0 tracks the block, copy 1 plans streams
  logic [7:0]  win_ram [2][RAM_DEPTH];
  int unsigned wr_idx [2];
  logic [31:0] prod_cnt [2];
  phase_t      ph [2];
  logic [7:0]  tok_flags [2];
  int unsigned tok_bit [2];
  logic [7:0]  ref_lo [2];
  int unsigned run_left [2];
  bit          stopped [2];
  logic [2:0]  cur_level = LVL_STORED;
  logic [31:0] cur_elen = '0;

  logic [7:0]  out_buf [BUF_MAX];
  int unsigned out_n;

  result_t     result_q [$];
  int unsigned n_pred = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned plan_pos;
  int unsigned plan_lenf;

  function automatic void restart(int s);
    wr_idx[s] = 0;
    prod_cnt[s] = '0;
    ph[s] = PH_FLAG;
    tok_flags[s] = '0;
    tok_bit[s] = 0;
    ref_lo[s] = '0;
    run_left[s] = 0;
    stopped[s] = 0;
  endfunction

  function automatic void put(int s, logic [7:0] b);
    if (out_n < BUF_MAX) begin
      out_buf[out_n] = b;
      out_n++;
    end
    prod_cnt[s] = prod_cnt[s] + 32'd1;
  endfunction

  function automatic void ring_put(int s, logic [7:0] b, int unsigned rs);
    if (wr_idx[s] >= rs) wr_idx[s] = 0;
    win_ram[s][wr_idx[s]] = b;
    wr_idx[s] = (wr_idx[s] + 1 >= rs) ? 0 : wr_idx[s] + 1;
  endfunction

  function automatic int unsigned ring_len(logic [2:0] lvl);
    int unsigned rs;
    rs = 1 << (14 - lvl);
    if (rs > RAM_DEPTH) rs = RAM_DEPTH;
    return rs;
  endfunction

  function automatic void advance_token(int s);
    if (tok_bit[s] >= 7) begin
      tok_bit[s] = 0;
      ph[s] = PH_FLAG;
    end else begin
      tok_bit[s]++;
      ph[s] = PH_LZ_ITEM;
    end
  endfunction

  function automatic bit lz_decode(int s, logic [7:0] b, logic [2:0] lvl);
    int unsigned rs, ob, pos, len;
    logic [7:0] c;
    bit err;
    rs = ring_len(lvl);
    ob = 6 - lvl;
    err = 0;
    if (ph[s] == PH_LZ_ITEM) begin
      if (tok_flags[s][tok_bit[s]]) begin
        put(s, b);
        ring_put(s, b, rs);
        advance_token(s);
      end else begin
        ref_lo[s] = b;
        ph[s] = PH_LZ_REF2;
      end
    end else if (ph[s] == PH_LZ_REF2) begin
      pos = ref_lo[s] | ((b & ((1 << ob) - 1)) << 8);
      len = 2 + (b >> ob);
      if (pos == 0) begin
        err = 1;
      end else begin
        pos--;
        for (int i = 0; i < len; i++) begin
          if (pos >= rs || pos >= prod_cnt[s]) begin
            err = 1;
            break;
          end
          c = win_ram[s][pos];
          ring_put(s, c, rs);
          put(s, c);
          pos = (pos + 1 >= rs) ? 0 : pos + 1;
        end
      end
      advance_token(s);
    end else begin
      tok_flags[s] = b;
      tok_bit[s] = 0;
      ph[s] = PH_LZ_ITEM;
    end
    return err;
  endfunction

  function automatic void rle_decode(int s, logic [7:0] b);
    if (ph[s] == PH_RLE_LIT) begin
      put(s, b);
      if (run_left[s] > 0) run_left[s]--;
      if (run_left[s] == 0) ph[s] = PH_FLAG;
    end else if (ph[s] == PH_RLE_REP) begin
      for (int i = 0; i < run_left[s]; i++) put(s, b);
      run_left[s] = 0;
      ph[s] = PH_FLAG;
    end else if (b > 8'd127) begin
      run_left[s] = b - 125;
      ph[s] = PH_RLE_REP;
    end else begin
      run_left[s] = b + 1;
      ph[s] = PH_RLE_LIT;
    end
  endfunction

  // decode one byte into out_buf and return the step status
  function automatic logic [1:0] decode_byte(int s, logic [7:0] b, logic fin);
    bit err;
    logic [1:0] st;
    err = 0;
    out_n = 0;
    if (!stopped[s]) begin
      if (cur_level == LVL_STORED) put(s, b);
      else if (cur_level == LVL_RLE) rle_decode(s, b);
      else if (cur_level != LVL_NONE) err = lz_decode(s, b, cur_level);
      if (err) stopped[s] = 1;
    end
    st = ST_OK;
    if (err) st = ST_BAD_REF;
    else if (fin && prod_cnt[s] != cur_elen) st = ST_LENGTH;
    if (fin) restart(s);
    return st;
  endfunction

  function automatic void predict_results(logic [7:0] b, logic fin);
    logic [1:0] st;
    int unsigned nres, cnt;
    result_t r;
    st = decode_byte(0, b, fin);
    nres = (out_n + 7) / 8;
    if (nres == 0 && (st != ST_OK || fin)) nres = 1;
    for (int k = 0; k < nres; k++) begin
      cnt = (out_n < k * 8) ? 0 : out_n - k * 8;
      if (cnt > 8) cnt = 8;
      r.data = '0;
      for (int j = 0; j < cnt; j++) r.data[8*j +: 8] = out_buf[k*8 + j];
      r.cnt = 4'(cnt);
      r.last = (k + 1 == nres);
      r.st = r.last ? st : ST_OK;
      result_q.push_back(r);
    end
    n_pred = nres;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("MISMATCH %s: expected %0h got %0h at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected result", '0, out_ch.out_bytes);
      end else begin
        w = result_q.pop_front();
        if (out_ch.out_bytes !== w.data) report("out_bytes", w.data, out_ch.out_bytes);
        if (out_ch.byte_count !== w.cnt) report("byte_count", w.cnt, out_ch.byte_count);
        if (out_ch.status !== w.st) report("status", w.st, out_ch.status);
        if (out_ch.run_last !== w.last) report("run_last", w.last, out_ch.run_last);
      end
    end
  end

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] lvl, logic [31:0] elen);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE_LEVEL;
    cfg_data <= {29'd0, lvl};
    @(posedge clk);
    cfg_index <= CFG_EXPECTED_LENGTH;
    cfg_data <= elen;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_level = lvl;
    cur_elen = elen;
  endtask

  // send one byte and return once it is accepted; predicted at acceptance
  task automatic send_byte(logic [7:0] b, logic fin);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    repeat (gap + 1) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.stream_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 1'b0;
    predict_results(b, fin);
  endtask

  function automatic void copy_state();
    for (int i = 0; i < RAM_DEPTH; i++) win_ram[1][i] = win_ram[0][i];
    wr_idx[1] = wr_idx[0];
    prod_cnt[1] = prod_cnt[0];
    ph[1] = ph[0];
    tok_flags[1] = tok_flags[0];
    tok_bit[1] = tok_bit[0];
    ref_lo[1] = ref_lo[0];
    run_left[1] = run_left[0];
    stopped[1] = stopped[0];
  endfunction

  // pick the next byte of a mostly well-formed stream from the planning copy
  function automatic logic [7:0] plan_byte(logic [2:0] lvl);
    int unsigned rs, ob, lim, maxf;
    logic [7:0] f;
    if (lvl == LVL_STORED || lvl == LVL_RLE || lvl == LVL_NONE)
      return ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom);
    rs = ring_len(lvl);
    ob = 6 - lvl;
    if (ph[1] == PH_LZ_ITEM) begin
      if (tok_flags[1][tok_bit[1]]) return 8'($urandom);
      lim = (prod_cnt[1] < rs - 1) ? prod_cnt[1] : rs - 1;
      if (lim == 0 || $urandom_range(24) == 0)
        plan_pos = (lim + 1 < rs && $urandom_range(1) == 1) ? lim + 1 : 0;
      else
        plan_pos = $urandom_range(lim, 1);
      maxf = 255 >> ob;
      plan_lenf = ($urandom_range(9) == 0) ? maxf : $urandom_range(maxf < 3 ? maxf : 3);
      return plan_pos[7:0];
    end
    if (ph[1] == PH_LZ_REF2) return 8'((plan_lenf << ob) | (plan_pos >> 8));
    f = 8'($urandom);
    if (prod_cnt[1] == 0) f[0] = 1'b1;
    return f;
  endfunction

  task automatic random_stream(output int unsigned n_sent);
    logic [2:0] lvl;
    logic [8:0] plan_q [$];
    logic [7:0] b;
    logic [31:0] elen;
    logic [1:0] st;
    int unsigned n, pick;
    bit noisy;
    pick = $urandom_range(99);
    if (pick < 10) lvl = LVL_STORED;
    else if (pick < 35) lvl = LVL_RLE;
    else if (pick < 95) lvl = 3'($urandom_range(6, 2));
    else lvl = LVL_NONE;
    n = $urandom_range(20, 2);
    noisy = ($urandom_range(9) == 0);
    drain();
    copy_state();
    cur_level = lvl;
    for (int i = 0; i < n; i++) begin
      b = noisy ? 8'($urandom) : plan_byte(lvl);
      plan_q.push_back({b, i == n - 1});
      st = decode_byte(1, b, 1'b0);
    end
    elen = prod_cnt[1];
    pick = $urandom_range(99);
    if (pick < 12) elen = elen + 32'd1;
    else if (pick < 20) elen = $urandom;
    else if (pick < 23) elen = 32'hFFFF_FFFF;
    write_cfg(lvl, elen);
    foreach (plan_q[i]) send_byte(plan_q[i][8:1], plan_q[i][0]);
    n_sent = n;
  endtask

  dir_row_t dir_tab [24] = '{
    '{1'b1, LVL_STORED, 32'd2, 8'h00, 1'b0, 1'b1, 64'h00, 4'd1, ST_OK},
    '{1'b0, LVL_STORED, 32'd0, 8'hFF, 1'b1, 1'b1, 64'hFF, 4'd1, ST_OK},
    '{1'b1, LVL_STORED, 32'hFFFF_FFFF, 8'h5A, 1'b1, 1'b1, 64'h5A, 4'd1, ST_LENGTH},
    '{1'b1, LVL_NONE, 32'd0, 8'h12, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, LVL_NONE, 32'd0, 8'h34, 1'b1, 1'b1, 64'h0, 4'd0, ST_OK},
    '{1'b1, LVL_RLE, 32'd135, 8'h80, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, LVL_RLE, 32'd0, 8'h41, 1'b0, 1'b1, 64'h414141, 4'd3, ST_OK},
    '{1'b0, LVL_RLE, 32'd0, 8'h01, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, LVL_RLE, 32'd0, 8'h10, 1'b0, 1'b1, 64'h10, 4'd1, ST_OK},
    '{1'b0, LVL_RLE, 32'd0, 8'h20, 1'b0, 1'b1, 64'h20, 4'd1, ST_OK},
    '{1'b0, LVL_RLE, 32'd0, 8'hFF, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, LVL_RLE, 32'd0, 8'h77, 1'b1, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b1, 3'd6, 32'd0, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, 3'd6, 32'd0, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, 3'd6, 32'd0, 8'h00, 1'b0, 1'b1, 64'h0, 4'd0, ST_BAD_REF},
    '{1'b0, 3'd6, 32'd0, 8'h99, 1'b1, 1'b1, 64'h0, 4'd0, ST_OK},
    '{1'b1, 3'd2, 32'd0, 8'h05, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, 3'd2, 32'd0, 8'h61, 1'b0, 1'b1, 64'h61, 4'd1, ST_OK},
    '{1'b0, 3'd2, 32'd0, 8'h01, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, 3'd2, 32'd0, 8'hF0, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, 3'd2, 32'd0, 8'h62, 1'b0, 1'b1, 64'h62, 4'd1, ST_OK},
    '{1'b0, 3'd2, 32'd0, 8'hC8, 1'b0, 1'b0, 64'h0, 4'd0, ST_OK},
    '{1'b0, 3'd2, 32'd0, 8'h00, 1'b0, 1'b1, 64'h0, 4'd0, ST_BAD_REF},
    '{1'b0, 3'd2, 32'd0, 8'h00, 1'b1, 1'b1, 64'h0, 4'd0, ST_LENGTH}
  };

  initial begin
    int unsigned sent;
    int unsigned n;
    result_t r;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.stream_end = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < RAM_DEPTH; i++) win_ram[0][i] = '0;
    restart(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].load_cfg) begin
        drain();
        write_cfg(dir_tab[i].lvl, dir_tab[i].elen);
      end
      send_byte(dir_tab[i].b, dir_tab[i].fin);
      if (dir_tab[i].typed) begin
        repeat (n_pred) void'(result_q.pop_back());
        r.data = dir_tab[i].data;
        r.cnt = dir_tab[i].cnt;
        r.st = dir_tab[i].st;
        r.last = 1'b1;
        result_q.push_back(r);
      end
    end

    sent = 0;
    for (int p = 0; p < 4; p++) begin
      drain();
      idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 83 : 25) : 0;
      stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 83 : 25) : 0;
      while (sent < (p + 1) * RAND_ITEMS / 4) begin
        random_stream(n);
        sent = sent + n;
      end
    end
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
